[rtl/core/bms_pkg.sv]
package bms_pkg;

   localparam int CAPACITY = 16;
   localparam int VALUE_W  = 32;
   localparam int SUM_W    = 36;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_LOOKUP = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_EMPTY   = 2'd2,
      STATUS_MISSING = 2'd3
   } status_type;

   // broadcast from the top level to every cell
   typedef struct packed {
      logic                       ins;
      logic                       rem;
      logic signed [VALUE_W-1:0]  value;
      logic        [COUNT_W-1:0]  count;
   } cell_ctl_type;

endpackage

[rtl/core/bms_req_if.sv]
interface bms_req_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         mode;
   logic signed [bms_pkg::VALUE_W-1:0] value;

   modport source (output valid, output mode, output value, input ready);
   modport sink   (input valid, input mode, input value, output ready);
endinterface

[rtl/core/bms_rsp_if.sv]
interface bms_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         status;
   logic                               found;
   logic [bms_pkg::COUNT_W-1:0]        position;
   logic [bms_pkg::COUNT_W-1:0]        entry_count;
   logic signed [bms_pkg::SUM_W-1:0]   total;

   modport source (output valid, output status, output found, output position,
                   output entry_count, output total, input ready);
   modport sink   (input valid, input status, input found, input position,
                   input entry_count, input total, output ready);
endinterface

[rtl/core/bms_cell.sv]
module bms_cell (
   input  logic                               clock,
   input  bms_pkg::cell_ctl_type              ctl,
   input  logic [bms_pkg::COUNT_W-1:0]        idx,
   input  logic                               hit_prev,
   input  logic signed [bms_pkg::VALUE_W-1:0] next_entry,
   output logic signed [bms_pkg::VALUE_W-1:0] entry,
   output logic                               hit_next,
   output logic                               first
);

   logic signed [bms_pkg::VALUE_W-1:0] entry_ff;
   logic signed [bms_pkg::VALUE_W-1:0] entry_in;
   logic                               live;
   logic                               hit;

   assign live     = idx < ctl.count;
   assign hit      = live && (entry_ff == ctl.value);
   assign first    = hit && !hit_prev;
   assign hit_next = hit_prev || hit;
   assign entry    = entry_ff;

   // cells at and after the first match pull from the right on remove
   always_comb begin
      priority if (ctl.ins && (idx == ctl.count)) begin
         entry_in = ctl.value;
      end else if (ctl.rem && hit_next) begin
         entry_in = next_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

[rtl/core/bounded_multiset_store_unit.sv]
// Bounded multiset store: up to CAPACITY signed 32-bit values held in insertion
// order in a row of cells, one value per cell. Every cell compares its value
// against the request at once and a match flag ripples along the row, so the
// first match is found, and on remove the matched and all later cells take their
// right neighbor's value, in the same cycle. One request is taken per clock; its
// response appears in an output register the next cycle and a new request is
// taken whenever that register is empty or being drained. Response fields:
// status (ok, full, empty, not found), found, position of the first match (or
// the count when absent), the count and the exact 36-bit sum after the
// operation. Mode three acts as a lookup.
module bounded_multiset_store_unit (
   input  logic      clock,
   input  logic      reset,
   bms_req_if.sink   req_bus,
   bms_rsp_if.source rsp_bus
);

   localparam int CAP = bms_pkg::CAPACITY;
   localparam int CW  = bms_pkg::COUNT_W;
   localparam int VW  = bms_pkg::VALUE_W;
   localparam int SW  = bms_pkg::SUM_W;

   logic [CW-1:0]        count_ff, count_in;
   logic signed [SW-1:0] sum_ff, sum_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   bms_pkg::status_type  status_ff, status_in;
   logic                 found_ff, found_in;
   logic [CW-1:0]        position_ff, position_in;

   logic                 req_fire;
   logic                 full;
   logic                 empty;
   logic signed [SW-1:0] value_ext;
   bms_pkg::cell_ctl_type ctl;

   logic [CAP:0]                 hit_chain;
   logic [CAP-1:0]               first_vec;
   logic signed [VW-1:0]         entry_bus [CAP];
   logic [CW-1:0]                match_pos;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign full          = count_ff >= CW'(CAP);
   assign empty         = count_ff == '0;
   assign value_ext     = {{(SW - VW){req_bus.value[VW-1]}}, req_bus.value};

   assign ctl.ins   = req_fire && (req_bus.mode == bms_pkg::MODE_INSERT) && !full;
   assign ctl.rem   = req_fire && (req_bus.mode == bms_pkg::MODE_REMOVE) && !empty;
   assign ctl.value = req_bus.value;
   assign ctl.count = count_ff;

   assign hit_chain[0] = 1'b0;

   for (genvar i = 0; i < CAP; i++) begin : g_cell
      logic signed [VW-1:0] right;
      if (i == CAP - 1) begin : g_last
         assign right = entry_bus[i];
      end else begin : g_mid
         assign right = entry_bus[i+1];
      end
      bms_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .idx        (CW'(i)),
         .hit_prev   (hit_chain[i]),
         .next_entry (right),
         .entry      (entry_bus[i]),
         .hit_next   (hit_chain[i+1]),
         .first      (first_vec[i])
      );
   end

   // at most one cell flags first, so OR its index in
   always_comb begin
      match_pos = '0;
      for (int i = 0; i < CAP; i++) begin
         match_pos = match_pos | (first_vec[i] ? CW'(i) : '0);
      end
   end

   always_comb begin
      count_in    = count_ff;
      sum_in      = sum_ff;
      status_in   = status_ff;
      found_in    = found_ff;
      position_in = position_ff;
      if (req_fire) begin
         found_in    = hit_chain[CAP];
         position_in = hit_chain[CAP] ? match_pos : count_ff;
         status_in   = bms_pkg::STATUS_OK;
         unique case (req_bus.mode)
            bms_pkg::MODE_INSERT: begin
               if (full) begin
                  status_in = bms_pkg::STATUS_FULL;
               end else begin
                  count_in = count_ff + CW'(1);
                  sum_in   = sum_ff + value_ext;
               end
            end
            bms_pkg::MODE_REMOVE: begin
               priority if (empty) begin
                  status_in   = bms_pkg::STATUS_EMPTY;
                  found_in    = 1'b0;
                  position_in = '0;
               end else if (!hit_chain[CAP]) begin
                  status_in = bms_pkg::STATUS_MISSING;
               end else begin
                  count_in = count_ff - CW'(1);
                  sum_in   = sum_ff - value_ext;
               end
            end
            default: begin
               // lookup; unused mode acts the same
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      found_ff    <= found_in;
      position_ff <= position_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.found       = found_ff;
   assign rsp_bus.position    = position_ff;
   assign rsp_bus.entry_count = count_ff;
   assign rsp_bus.total       = sum_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAP))
      else $error("occupancy beyond capacity");

   a_first_unique : assert property (@(posedge clock) disable iff (reset)
      $onehot0(first_vec))
      else $error("more than one first match");

   a_insert_grows : assert property (@(posedge clock) disable iff (reset)
      ctl.ins |=> count_ff == CW'($past(count_ff) + CW'(1)))
      else $error("insert did not advance count");

   a_remove_shrinks : assert property (@(posedge clock) disable iff (reset)
      ctl.rem && hit_chain[CAP] |=> count_ff == CW'($past(count_ff) - CW'(1)))
      else $error("remove did not drop count");

endmodule

[sim/tb_bounded_multiset_store_unit.sv]
module tb_bounded_multiset_store_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         CYCLE_LIMIT = 400000;
   localparam int         PRINT_LIMIT = 100;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic signed [bms_pkg::VALUE_W-1:0] VALUE_MAX =
      {1'b0, {(bms_pkg::VALUE_W-1){1'b1}}};
   localparam logic signed [bms_pkg::VALUE_W-1:0] VALUE_MIN =
      {1'b1, {(bms_pkg::VALUE_W-1){1'b0}}};

   typedef struct packed {
      bms_pkg::status_type              status;
      logic                             found;
      logic [bms_pkg::COUNT_W-1:0]      position;
      logic [bms_pkg::COUNT_W-1:0]      entry_count;
      logic signed [bms_pkg::SUM_W-1:0] total;
   } reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bms_req_if req_bus ();
   bms_rsp_if rsp_bus ();

   bounded_multiset_store_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #5 clock = ~clock;

   // shadow copy of the store contents
   logic signed [bms_pkg::VALUE_W-1:0] shadow_entries [bms_pkg::CAPACITY];
   int                                 shadow_count = 0;
   logic signed [bms_pkg::SUM_W-1:0]   shadow_sum = '0;

   reply_type                          replies_due [$];
   reply_type                          want_reply;
   logic signed [bms_pkg::VALUE_W-1:0] value_pool [8];

   int mismatches = 0;
   int requests_sent = 0;
   int replies_seen = 0;
   int status_seen [4] = '{default: 0};
   int cycle_count = 0;
   int stall_left = 0;
   bit req_gaps_on = 1'b0;
   bit rsp_stalls_on = 1'b0;

   function automatic reply_type apply_to_shadow(
      input logic [1:0]                         mode,
      input logic signed [bms_pkg::VALUE_W-1:0] value
   );
      reply_type r;
      int        hit_at;
      hit_at = shadow_count;
      for (int i = shadow_count - 1; i >= 0; i--) begin
         if (shadow_entries[i] == value) hit_at = i;
      end
      r.status   = bms_pkg::STATUS_OK;
      r.found    = (hit_at < shadow_count);
      r.position = bms_pkg::COUNT_W'(hit_at);
      case (mode)
         bms_pkg::MODE_INSERT: begin
            if (shadow_count >= bms_pkg::CAPACITY) begin
               r.status = bms_pkg::STATUS_FULL;
            end else begin
               shadow_entries[shadow_count] = value;
               shadow_count++;
               shadow_sum = shadow_sum + value;
            end
         end
         bms_pkg::MODE_REMOVE: begin
            if (shadow_count == 0) begin
               r.status   = bms_pkg::STATUS_EMPTY;
               r.found    = 1'b0;
               r.position = '0;
            end else if (!r.found) begin
               r.status = bms_pkg::STATUS_MISSING;
            end else begin
               // close the gap left by the removed entry
               for (int i = hit_at; i < shadow_count - 1; i++) begin
                  shadow_entries[i] = shadow_entries[i + 1];
               end
               shadow_count--;
               shadow_sum = shadow_sum - value;
            end
         end
         default: begin
         end
      endcase
      r.entry_count = bms_pkg::COUNT_W'(shadow_count);
      r.total       = shadow_sum;
      return r;
   endfunction

   function automatic logic signed [bms_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: begin
            return $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
         end
         1, 2: begin
            return $urandom();
         end
         default: begin
            return value_pool[$urandom_range(0, 7)];
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      // keep the log short when something breaks badly
      if (mismatches <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, what);
   endtask

   task automatic check_field(input string name, input logic signed [63:0] got,
                              input logic signed [63:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("reply %0d %s: got %0d, expected %0d",
                                   replies_seen, name, got, want));
      end
   endtask

   // Called just after a falling edge; returns just after the next falling edge
   // following acceptance of the beat.
   task automatic send_request(input logic [1:0] mode,
                               input logic signed [bms_pkg::VALUE_W-1:0] value);
      if (req_gaps_on && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode  <= mode;
      req_bus.value <= value;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      replies_due.push_back(apply_to_shadow(mode, value));
      requests_sent++;
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         replies_seen++;
         if (replies_due.size() == 0) begin
            report_mismatch($sformatf("reply %0d with nothing outstanding, status %0d",
                                      replies_seen, rsp_bus.status));
         end else begin
            want_reply = replies_due.pop_front();
            status_seen[want_reply.status]++;
            check_field("status", rsp_bus.status, want_reply.status);
            check_field("found", rsp_bus.found, want_reply.found);
            check_field("position", rsp_bus.position, want_reply.position);
            check_field("entry_count", rsp_bus.entry_count, want_reply.entry_count);
            check_field("total", rsp_bus.total, want_reply.total);
         end
      end
   end

   // reply backpressure in bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_stalls_on && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(1, 9) - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d replies outstanding",
                  cycle_count, replies_due.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic test_directed_cases();
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b1;
      send_request(bms_pkg::MODE_REMOVE, 32'sd5);
      send_request(bms_pkg::MODE_LOOKUP, 32'sd5);
      send_request(MODE_UNUSED, 32'sd7);
      send_request(bms_pkg::MODE_INSERT, VALUE_MIN);
      send_request(bms_pkg::MODE_INSERT, VALUE_MAX);
      send_request(bms_pkg::MODE_INSERT, 32'sd0);
      send_request(bms_pkg::MODE_INSERT, -32'sd1);
      send_request(bms_pkg::MODE_INSERT, VALUE_MAX);
      send_request(bms_pkg::MODE_LOOKUP, VALUE_MAX);
      send_request(MODE_UNUSED, -32'sd1);
      send_request(bms_pkg::MODE_LOOKUP, 32'sd12345);
      send_request(bms_pkg::MODE_REMOVE, 32'sd12345);
      send_request(bms_pkg::MODE_REMOVE, VALUE_MAX);
      send_request(bms_pkg::MODE_LOOKUP, VALUE_MAX);
      send_request(bms_pkg::MODE_INSERT, 32'h5555_5555);
      send_request(bms_pkg::MODE_LOOKUP, 32'hAAAA_AAAA);
      send_request(bms_pkg::MODE_INSERT, 32'hAAAA_AAAA);
      send_request(bms_pkg::MODE_REMOVE, VALUE_MIN);
      send_request(bms_pkg::MODE_REMOVE, 32'h5555_5555);
      send_request(bms_pkg::MODE_REMOVE, 32'hAAAA_AAAA);
      send_request(bms_pkg::MODE_REMOVE, -32'sd1);
      send_request(bms_pkg::MODE_REMOVE, 32'sd0);
      send_request(bms_pkg::MODE_REMOVE, VALUE_MAX);
      send_request(bms_pkg::MODE_REMOVE, VALUE_MAX);
   endtask

   // for four value kinds: fill to capacity, push against the full store, then drain to empty
   task automatic test_full_and_empty_cycles();
      logic signed [bms_pkg::VALUE_W-1:0] value;
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      for (int kind = 0; kind < 4; kind++) begin
         for (int i = 0; i < 8; i++) value_pool[i] = $urandom_range(0, 5) - 2;
         while (shadow_count < bms_pkg::CAPACITY) begin
            case (kind)
               0: begin
                  value = VALUE_MAX;
               end
               1: begin
                  value = VALUE_MIN;
               end
               2: begin
                  value = $urandom();
               end
               default: begin
                  value = pick_value();
               end
            endcase
            send_request(bms_pkg::MODE_INSERT, value);
         end
         send_request(bms_pkg::MODE_INSERT, shadow_entries[bms_pkg::CAPACITY - 1]);
         send_request(bms_pkg::MODE_INSERT, $urandom());
         send_request(bms_pkg::MODE_LOOKUP,
                      shadow_entries[$urandom_range(0, bms_pkg::CAPACITY - 1)]);
         while (shadow_count > 0) begin
            if ($urandom_range(0, 7) == 0) begin
               send_request(bms_pkg::MODE_REMOVE, $urandom());
            end else begin
               send_request(bms_pkg::MODE_REMOVE,
                            shadow_entries[$urandom_range(0, shadow_count - 1)]);
            end
         end
         send_request(bms_pkg::MODE_REMOVE, pick_value());
      end
   endtask

   task automatic test_mixed_traffic(input int items, input bit allow_idling);
      logic [1:0]                         mode;
      logic signed [bms_pkg::VALUE_W-1:0] value;
      int                                 insert_pct;
      int                                 roll;
      insert_pct = 40;
      for (int n = 0; n < items; n++) begin
         // new value pool, operation mix and idling every chunk
         if (n % 64 == 0) begin
            for (int i = 0; i < 8; i++) begin
               value_pool[i] = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 20) - 10;
            end
            insert_pct    = $urandom_range(25, 60);
            req_gaps_on   = allow_idling && $urandom_range(0, 2) != 0;
            rsp_stalls_on = allow_idling && $urandom_range(0, 2) != 0;
         end
         roll = $urandom_range(0, 99);
         if (roll < insert_pct) mode = bms_pkg::MODE_INSERT;
         else if (roll < 85) mode = bms_pkg::MODE_REMOVE;
         else if (roll < 97) mode = bms_pkg::MODE_LOOKUP;
         else mode = MODE_UNUSED;
         if (mode != bms_pkg::MODE_INSERT && shadow_count > 0 &&
             $urandom_range(0, 9) < 6) begin
            value = shadow_entries[$urandom_range(0, shadow_count - 1)];
         end else begin
            value = pick_value();
         end
         send_request(mode, value);
      end
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.mode  = bms_pkg::MODE_INSERT;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_full_and_empty_cycles();
      test_mixed_traffic(950, 1'b1);
      test_mixed_traffic(150, 1'b0);

      req_bus.valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);

      $display("Sent %0d requests in %0d cycles, checked %0d replies, %0d mismatches",
               requests_sent, cycle_count, replies_seen, mismatches);
      $display("Reply status mix: %0d ok, %0d full, %0d empty, %0d not found",
               status_seen[bms_pkg::STATUS_OK], status_seen[bms_pkg::STATUS_FULL],
               status_seen[bms_pkg::STATUS_EMPTY], status_seen[bms_pkg::STATUS_MISSING]);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
